FILE: hw/rtl/rtb_pkg.sv
package rtb_pkg;

  // Field widths.
  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 16;
  localparam int DBAND_W    = 12;
  localparam int HOLD_W     = 22;
  localparam int QUOT_W     = 16;
  localparam int PROD_W     = TIME_W + QUOT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  // Operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RAMP   = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON   = 2'd2;

  // Reset values.
  localparam logic signed [TEMP_W-1:0] SETPOINT_RST = 16'sd6400;
  localparam logic [DBAND_W-1:0]       DEADBAND_RST = 12'd256;
  localparam logic [HOLD_W-1:0]        MIN_OFF_RST  = 22'd180000;
  localparam logic [HOLD_W-1:0]        MIN_ON_RST   = 22'd60000;
  localparam logic [TIME_W-1:0]        LAST_OFF_RST = 32'd0 - {10'd0, MIN_OFF_RST};

  typedef struct packed {
    logic                     operation;
    logic [TIME_W-1:0]        now_ms;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [TEMP_W-1:0] ramp_target;
    logic [TIME_W-1:0]        ramp_duration_ms;
  } in_word_t;

  typedef struct packed {
    logic                     compressor_on;
    logic                     heater_on;
    logic signed [TEMP_W-1:0] setpoint;
  } out_word_t;

endpackage

FILE: hw/rtl/ramped_thermostat_bang_bang_top.sv
// Channel   Signals                                  Direction
// input     in_valid, in_ready, in_word              item in
// output    out_valid, out_ready, out_word           result out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// A ramp word goes from acceptance straight to the result load. A sample word
// passes setup, decision and result load; when the setpoint lies inside a
// running ramp, the serial multiplier and divider run in between, one bit per cycle.
// Synchronous reset restores the setpoint, ramp, timers and relays at once.
// One word is in work at a time; a finished result waits in the output register
// and a stalled output holds the next result until the register frees.
module ramped_thermostat_bang_bang_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rtb_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rtb_pkg::out_word_t                out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rtb_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]               state;
  logic [2:0]               state_next;

  logic [DBAND_W-1:0]       deadband;
  logic [HOLD_W-1:0]        min_off_time;
  logic [HOLD_W-1:0]        min_on_time;

  logic signed [TEMP_W-1:0] setpoint;
  logic signed [TEMP_W-1:0] ramp_start;
  logic signed [TEMP_W-1:0] ramp_end;
  logic [TIME_W-1:0]        ramp_time;
  logic [TIME_W-1:0]        ramp_len;
  logic [TIME_W-1:0]        last_on;
  logic [TIME_W-1:0]        last_off;
  logic                     compressor;
  logic                     heater;

  logic [TIME_W-1:0]        item_now;
  logic signed [TEMP_W-1:0] item_temp;

  logic [TIME_W-1:0]        elapsed;
  logic                     ramp_done;
  logic signed [TEMP_W:0]   diff;
  logic [TEMP_W:0]          diff_abs;
  logic                     mul_start;
  logic                     mul_done;
  logic [PROD_W-1:0]        product;
  logic                     div_done;
  logic [QUOT_W-1:0]        quotient;
  logic [TEMP_W:0]          step;
  logic signed [TEMP_W-1:0] sp_interp;

  logic signed [TEMP_W+1:0] t_x;
  logic signed [TEMP_W+1:0] s_x;
  logic signed [TEMP_W+1:0] d_x;
  logic                     hot;
  logic                     cold;
  logic                     near;
  logic                     off_ok;
  logic                     on_ok;
  logic                     stop_ok;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Ramp position and interpolation operands.
  assign elapsed   = item_now - ramp_time;
  assign ramp_done = (elapsed >= ramp_len);
  assign diff      = {ramp_end[TEMP_W-1], ramp_end} - {ramp_start[TEMP_W-1], ramp_start};
  assign diff_abs  = diff[TEMP_W] ? (TEMP_W+1)'(-diff) : diff;
  assign mul_start = (state == ST_SETUP) && (ramp_len != '0) && !ramp_done;

  rtb_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mag     (diff_abs[QUOT_W-1:0]),
    .elapsed (elapsed),
    .done    (mul_done),
    .product (product)
  );

  rtb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_done),
    .dividend (product),
    .divisor  (ramp_len),
    .done     (div_done),
    .quotient (quotient)
  );

  // The quotient is a magnitude; restore the sign of the ramp direction.
  assign step      = diff[TEMP_W] ? (TEMP_W+1)'(-{1'b0, quotient}) : {1'b0, quotient};
  assign sp_interp = ramp_start + step[TEMP_W-1:0];

  // Band tests around the setpoint, with headroom for doubled values.
  assign t_x    = {{2{item_temp[TEMP_W-1]}}, item_temp};
  assign s_x    = {{2{setpoint[TEMP_W-1]}}, setpoint};
  assign d_x    = {{(TEMP_W+2-DBAND_W){1'b0}}, deadband};
  assign hot    = (t_x > s_x + d_x);
  assign cold   = (t_x < s_x - d_x);
  assign near   = ((t_x <<< 1) > (s_x <<< 1) - d_x) && ((t_x <<< 1) < (s_x <<< 1) + d_x);
  assign off_ok = ((item_now - last_off) >= {{(TIME_W-HOLD_W){1'b0}}, min_off_time});
  assign on_ok  = ((item_now - last_on) >= {{(TIME_W-HOLD_W){1'b0}}, min_on_time});
  assign stop_ok = compressor && on_ok;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = (in_word.operation == OP_RAMP) ? ST_OUT : ST_SETUP;
      ST_SETUP:  state_next = mul_start ? ST_MUL : ST_DECIDE;
      ST_MUL:    if (mul_done) state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband     <= DEADBAND_RST;
      min_off_time <= MIN_OFF_RST;
      min_on_time  <= MIN_ON_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEADBAND: deadband     <= cfg_data[DBAND_W-1:0];
        CFG_MIN_OFF:  min_off_time <= cfg_data[HOLD_W-1:0];
        CFG_MIN_ON:   min_on_time  <= cfg_data[HOLD_W-1:0];
        default:      ;
      endcase
    end
  end

  // Accepted word: a ramp is recorded at once, a sample is held for the sequence.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_now  <= in_word.now_ms;
      item_temp <= in_word.temperature;
    end
  end

  // Ramp and thermostat state.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= SETPOINT_RST;
      ramp_start <= SETPOINT_RST;
      ramp_end   <= SETPOINT_RST;
      ramp_time  <= '0;
      ramp_len   <= '0;
      last_on    <= '0;
      last_off   <= LAST_OFF_RST;
      compressor <= 1'b0;
      heater     <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_valid && in_word.operation == OP_RAMP) begin
        ramp_start <= in_word.temperature;
        ramp_end   <= in_word.ramp_target;
        ramp_time  <= in_word.now_ms;
        ramp_len   <= in_word.ramp_duration_ms;
      end
      if (state == ST_SETUP && ramp_len != '0 && ramp_done) begin
        setpoint <= ramp_end;
      end
      if (state == ST_DIV && div_done) begin
        setpoint <= sp_interp;
      end
      if (state == ST_DECIDE) begin
        if (hot) begin
          heater <= 1'b0;
          if (!compressor && off_ok) begin
            compressor <= 1'b1;
            last_on    <= item_now;
          end
        end else if (cold || near) begin
          heater <= cold;
          if (stop_ok) begin
            compressor <= 1'b0;
            last_off   <= item_now;
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_word.compressor_on <= compressor;
      out_word.heater_on     <= heater;
      out_word.setpoint      <= setpoint;
    end
  end

  // The serial units finish only while the sequencer waits on them.
  assert property (@(posedge clk) disable iff (rst) mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside its wait state");
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");
  assert property (@(posedge clk) disable iff (rst) state == ST_DECIDE |=> state == ST_OUT)
    else $error("decision not followed by result load");
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in work");

endmodule

FILE: hw/rtl/rtb_mul.sv
// Serial shift-add multiplier: one bit of the multiplier per cycle, MSB first.
module rtb_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rtb_pkg::QUOT_W-1:0]  mag,
  input  logic [rtb_pkg::TIME_W-1:0]  elapsed,
  output logic                        done,
  output logic [rtb_pkg::PROD_W-1:0]  product
);
  import rtb_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [QUOT_W-1:0] mag_sh;
  logic [TIME_W-1:0] mcand;

  // Control: count the multiplier bits and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(QUOT_W);
    end else if (busy) begin
      busy <= (cnt != CNT_W'(1));
      done <= (cnt == CNT_W'(1));
      cnt  <= cnt - CNT_W'(1);
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: double the partial product and add the multiplicand when the bit is set.
  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      mag_sh  <= mag;
      mcand   <= elapsed;
    end else if (busy) begin
      product <= {product[PROD_W-2:0], 1'b0}
               + (mag_sh[QUOT_W-1] ? {{QUOT_W{1'b0}}, mcand} : '0);
      mag_sh  <= {mag_sh[QUOT_W-2:0], 1'b0};
    end
  end

endmodule

FILE: hw/rtl/rtb_div.sv
// Restoring divider: one quotient bit per cycle. The quotient is known to fit
// in QUOT_W bits, so the upper dividend bits start as the partial remainder.
module rtb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rtb_pkg::PROD_W-1:0]  dividend,
  input  logic [rtb_pkg::TIME_W-1:0]  divisor,
  output logic                        done,
  output logic [rtb_pkg::QUOT_W-1:0]  quotient
);
  import rtb_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvsr;
  logic [TIME_W:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the remainder and try the subtraction.
  assign trial = {rem, quotient[QUOT_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  // Control: count the quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(QUOT_W);
    end else if (busy) begin
      busy <= (cnt != CNT_W'(1));
      done <= (cnt == CNT_W'(1));
      cnt  <= cnt - CNT_W'(1);
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: the low dividend bits shift out as the quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[PROD_W-1:QUOT_W];
      quotient <= dividend[QUOT_W-1:0];
      dvsr     <= divisor;
    end else if (busy) begin
      rem      <= fits ? TIME_W'(trial - {1'b0, dvsr}) : trial[TIME_W-1:0];
      quotient <= {quotient[QUOT_W-2:0], fits};
    end
  end

endmodule
